// ===== rtl/core/irpw_pkg.sv =====
// Shared types and constants for the IR pulse-width frame decoder.
package irpw_pkg;

    localparam int DUR_W  = 8;
    localparam int CODE_W = 32;
    localparam int CFG_W  = 8;
    localparam int IDX_W  = 2;

    localparam logic [CFG_W-1:0] LEADER_MIN_RST = 8'h07;
    localparam logic [CFG_W-1:0] LEADER_MAX_RST = 8'h09;
    localparam logic [CFG_W-1:0] ONE_MIN_RST    = 8'h13;
    localparam logic [CFG_W-1:0] ONE_MAX_RST    = 8'h18;

    typedef enum logic [IDX_W-1:0] {
        CFG_LEADER_MIN = 2'd0,
        CFG_LEADER_MAX = 2'd1,
        CFG_ONE_MIN    = 2'd2,
        CFG_ONE_MAX    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] leader_min;
        logic [CFG_W-1:0] leader_max;
        logic [CFG_W-1:0] one_min;
        logic [CFG_W-1:0] one_max;
    } t_cfg;

    typedef struct packed {
        logic is_leader;
        logic is_one;
    } t_class;

endpackage

// ===== rtl/core/irpw_dur_if.sv =====
// Stream interface that carries one measured pulse duration per beat.
interface irpw_dur_if;
    logic                       valid;
    logic                       ready;
    logic [irpw_pkg::DUR_W-1:0] duration;

    modport source (output valid, output duration, input ready);
    modport sink (input valid, input duration, output ready);
endinterface

// ===== rtl/core/irpw_code_if.sv =====
// Stream interface that carries one decoded frame code per beat.
interface irpw_code_if;
    logic                        valid;
    logic                        ready;
    logic [irpw_pkg::CODE_W-1:0] code;

    modport source (output valid, output code, input ready);
    modport sink (input valid, input code, output ready);
endinterface

// ===== rtl/core/irpw_classify.sv =====
// Window compares that classify one duration as leader and as one bit.
module irpw_classify (
    input  logic [irpw_pkg::DUR_W-1:0] i_duration,
    input  irpw_pkg::t_cfg             i_cfg,
    output irpw_pkg::t_class           o_class
);
    import irpw_pkg::*;

    always_comb begin
        o_class.is_leader = (i_duration >= i_cfg.leader_min) &&
                            (i_duration <= i_cfg.leader_max);
        o_class.is_one    = (i_duration >= i_cfg.one_min) &&
                            (i_duration <= i_cfg.one_max);
    end
endmodule

// ===== rtl/core/ir_pulse_width_frame_decoder.sv =====
// Top level of the IR pulse-width frame decoder.
// Durations enter an input register, are classified against the leader and
// one-bit windows and update the frame state as that register advances; a
// finished frame code lands in an output register. One duration beat is
// accepted per cycle unless the output stalls: both stages advance together,
// so a stalled output holds the input register. While idle, a duration in the
// leader window opens a frame; the next BITS durations give code bits, least
// significant first, and bits past 32 are dropped. The user writes registers
// through the plain write port only while idle; the block does not enforce it.
module ir_pulse_width_frame_decoder #(
    parameter int BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [irpw_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [irpw_pkg::CFG_W-1:0] i_cfg_data,
    irpw_dur_if.sink                   i_in,
    irpw_code_if.source                o_out
);
    import irpw_pkg::*;

    localparam int CNT_W = $clog2(BITS);

    t_cfg              r_cfg;
    logic              r_s_valid;
    logic [DUR_W-1:0]  r_s_dur;
    logic              r_collecting;
    logic [CNT_W-1:0]  r_cnt;
    logic [CODE_W-1:0] r_shift;
    logic              r_out_valid;
    logic [CODE_W-1:0] r_out_code;

    logic              advance;
    logic              work;
    logic              last_bit;
    logic [CODE_W-1:0] n_shift;
    t_class            cls;

    irpw_classify u_classify (
        .i_duration (r_s_dur),
        .i_cfg      (r_cfg),
        .o_class    (cls)
    );

    assign advance     = !r_out_valid || o_out.ready;
    assign work        = r_s_valid && advance;
    assign i_in.ready  = !r_s_valid || advance;
    assign o_out.valid = r_out_valid;
    assign o_out.code  = r_out_code;
    assign last_bit    = (r_cnt == CNT_W'(BITS - 1));

    always_comb begin
        n_shift = r_shift;
        if (cls.is_one && ((7'(r_cnt)) < 7'd32)) begin
            n_shift = r_shift | (CODE_W'(1) << 5'(r_cnt));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.leader_min <= LEADER_MIN_RST;
            r_cfg.leader_max <= LEADER_MAX_RST;
            r_cfg.one_min    <= ONE_MIN_RST;
            r_cfg.one_max    <= ONE_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_LEADER_MIN: r_cfg.leader_min <= i_cfg_data;
                CFG_LEADER_MAX: r_cfg.leader_max <= i_cfg_data;
                CFG_ONE_MIN:    r_cfg.one_min    <= i_cfg_data;
                CFG_ONE_MAX:    r_cfg.one_max    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s_dur <= i_in.duration;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_collecting <= 1'b0;
            r_cnt        <= '0;
            r_shift      <= '0;
        end else if (work) begin
            if (!r_collecting) begin
                if (cls.is_leader) begin
                    r_collecting <= 1'b1;
                    r_cnt        <= '0;
                    r_shift      <= '0;
                end
            end else if (last_bit) begin
                r_collecting <= 1'b0;
                r_cnt        <= '0;
                r_shift      <= '0;
            end else begin
                r_cnt   <= r_cnt + CNT_W'(1);
                r_shift <= n_shift;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= work && r_collecting && last_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (work && r_collecting && last_bit) begin
            r_out_code <= n_shift;
        end
    end

`ifndef SYNTHESIS
    a_cnt_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> r_collecting)
        else $error("Bit counter runs outside a frame.");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        7'(r_cnt) < 7'(BITS))
        else $error("Bit counter passed the frame length.");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s_valid && !advance) |=> (r_s_valid && $stable(r_s_dur)))
        else $error("Input register lost a beat while stalled.");

    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (work && r_collecting && last_bit) |=> (r_out_valid && !r_collecting))
        else $error("Frame end did not produce a code beat.");
`endif
endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the IR pulse-width frame decoder.
`timescale 1ns / 1ps

module tb_top;
    import irpw_pkg::*;

    localparam int FRAME_BITS = 32;
    localparam int RAND_BEATS = 1300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 4;

    typedef enum logic {
        ROW_REG,
        ROW_FRAME
    } t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        t_cfg_idx         idx;
        logic [7:0]       lead;
        logic [7:0]       one_d;
        logic [7:0]       zero_d;
        logic [31:0]      bits;
        logic             chk;
        logic [31:0]      code;
    } t_row;

    localparam int NROWS = 24;
    localparam t_row DIRECTED [NROWS] = '{
        '{ROW_FRAME, CFG_LEADER_MIN, 8'd7,   8'd19,  8'd0,   32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
        '{ROW_FRAME, CFG_LEADER_MIN, 8'd9,   8'd24,  8'd255, 32'h00000000, 1'b1, 32'h00000000},
        '{ROW_FRAME, CFG_LEADER_MIN, 8'd8,   8'd21,  8'd25,  32'h12345678, 1'b0, 32'h00000000},
        '{ROW_FRAME, CFG_LEADER_MIN, 8'd8,   8'd18,  8'd7,   32'hA5A5A5A5, 1'b1, 32'h00000000},
        '{ROW_FRAME, CFG_LEADER_MIN, 8'd7,   8'd20,  8'd9,   32'h0000FFFF, 1'b1, 32'h0000FFFF},
        '{ROW_FRAME, CFG_LEADER_MIN, 8'd6,   8'd255, 8'd10,  32'h5555AAAA, 1'b0, 32'h00000000},
        '{ROW_FRAME, CFG_LEADER_MIN, 8'd10,  8'd0,   8'd128, 32'hF0F0F0F0, 1'b0, 32'h00000000},
        '{ROW_REG,   CFG_LEADER_MIN, 8'd0,   8'd0,   8'd0,   32'h0,        1'b0, 32'h0},
        '{ROW_REG,   CFG_LEADER_MAX, 8'd255, 8'd0,   8'd0,   32'h0,        1'b0, 32'h0},
        '{ROW_REG,   CFG_ONE_MIN,    8'd0,   8'd0,   8'd0,   32'h0,        1'b0, 32'h0},
        '{ROW_REG,   CFG_ONE_MAX,    8'd255, 8'd0,   8'd0,   32'h0,        1'b0, 32'h0},
        '{ROW_FRAME, CFG_LEADER_MIN, 8'd0,   8'd255, 8'd0,   32'h3C3C3C3C, 1'b1, 32'hFFFFFFFF},
        '{ROW_FRAME, CFG_LEADER_MIN, 8'd255, 8'd128, 8'd1,   32'h00000000, 1'b1, 32'hFFFFFFFF},
        '{ROW_REG,   CFG_ONE_MIN,    8'd200, 8'd0,   8'd0,   32'h0,        1'b0, 32'h0},
        '{ROW_REG,   CFG_ONE_MAX,    8'd100, 8'd0,   8'd0,   32'h0,        1'b0, 32'h0},
        '{ROW_FRAME, CFG_LEADER_MIN, 8'd0,   8'd150, 8'd255, 32'hDEADBEEF, 1'b1, 32'h00000000},
        '{ROW_REG,   CFG_LEADER_MIN, 8'd255, 8'd0,   8'd0,   32'h0,        1'b0, 32'h0},
        '{ROW_REG,   CFG_LEADER_MAX, 8'd0,   8'd0,   8'd0,   32'h0,        1'b0, 32'h0},
        '{ROW_FRAME, CFG_LEADER_MIN, 8'd255, 8'd0,   8'd128, 32'h0F0F0F0F, 1'b0, 32'h00000000},
        '{ROW_REG,   CFG_LEADER_MIN, 8'd255, 8'd0,   8'd0,   32'h0,        1'b0, 32'h0},
        '{ROW_REG,   CFG_LEADER_MAX, 8'd255, 8'd0,   8'd0,   32'h0,        1'b0, 32'h0},
        '{ROW_REG,   CFG_ONE_MIN,    8'd255, 8'd0,   8'd0,   32'h0,        1'b0, 32'h0},
        '{ROW_REG,   CFG_ONE_MAX,    8'd255, 8'd0,   8'd0,   32'h0,        1'b0, 32'h0},
        '{ROW_FRAME, CFG_LEADER_MIN, 8'd255, 8'd255, 8'd254, 32'h80000001, 1'b1, 32'h80000001}
    };

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    t_cfg_idx         i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    irpw_dur_if  dur_if ();
    irpw_code_if code_if ();

    ir_pulse_width_frame_decoder #(
        .BITS(FRAME_BITS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (dur_if.sink),
        .o_out      (code_if.source)
    );

    t_cfg        cur_cfg;
    logic        collecting;
    logic [5:0]  bit_cnt;
    logic [31:0] code_acc;
    logic [31:0] pending_codes [$];
    logic        typed_on;
    logic [31:0] typed_code;
    int          busy_beats;
    int          errors;
    int          cycle;
    logic        no_gaps;

    assign no_gaps = (cycle >= 1000) && (cycle < 2000);

    initial begin
        i_clk = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle >= CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    function automatic void decode_duration(input logic [7:0] d);
        logic [31:0] acc;
        if (!collecting) begin
            if (d >= cur_cfg.leader_min && d <= cur_cfg.leader_max) begin
                collecting = 1'b1;
                bit_cnt = '0;
                code_acc = '0;
                busy_beats++;
            end
            return;
        end
        busy_beats++;
        acc = code_acc;
        if (!bit_cnt[5] && d >= cur_cfg.one_min && d <= cur_cfg.one_max)
            acc[bit_cnt[4:0]] = 1'b1;
        if (bit_cnt == 6'(FRAME_BITS - 1)) begin
            pending_codes.push_back(typed_on ? typed_code : acc);
            collecting = 1'b0;
            bit_cnt = '0;
            code_acc = '0;
        end else begin
            bit_cnt = bit_cnt + 6'd1;
            code_acc = acc;
        end
    endfunction

    function automatic logic [7:0] pick_in(input logic [7:0] lo, input logic [7:0] hi);
        if (lo > hi)
            return 8'($urandom_range(255));
        return 8'($urandom_range(int'(hi), int'(lo)));
    endfunction

    function automatic logic [7:0] pick_out(input logic [7:0] lo, input logic [7:0] hi);
        if (lo > hi || (lo == 8'd0 && hi == 8'd255))
            return 8'($urandom_range(255));
        if (lo == 8'd0 || (hi != 8'd255 && $urandom_range(1) == 1))
            return 8'($urandom_range(255, int'(hi) + 1));
        return 8'($urandom_range(int'(lo) - 1, 0));
    endfunction

    function automatic logic [7:0] rand_bound();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic rand_window(output logic [7:0] lo, output logic [7:0] hi);
        int span;
        lo = rand_bound();
        span = int'(lo) + int'($urandom_range(40));
        if ($urandom_range(4) == 0)
            hi = rand_bound();
        else
            hi = (span > 255) ? 8'd255 : 8'(span);
    endtask

    // One duration beat; the sender idles at random before offering it.
    task automatic send_dur(input logic [7:0] d);
        @(negedge i_clk);
        while (!no_gaps && $urandom_range(99) < 34) begin
            dur_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        dur_if.valid <= 1'b1;
        dur_if.duration <= d;
        @(posedge i_clk);
        while (!dur_if.ready)
            @(posedge i_clk);
        decode_duration(d);
    endtask

    task automatic drain();
        @(negedge i_clk);
        dur_if.valid <= 1'b0;
        while (pending_codes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        case (idx)
            CFG_LEADER_MIN: cur_cfg.leader_min = v;
            CFG_LEADER_MAX: cur_cfg.leader_max = v;
            CFG_ONE_MIN:    cur_cfg.one_min = v;
            CFG_ONE_MAX:    cur_cfg.one_max = v;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure_random();
        logic [7:0] lo;
        logic [7:0] hi;
        drain();
        rand_window(lo, hi);
        write_reg(CFG_LEADER_MIN, lo);
        write_reg(CFG_LEADER_MAX, hi);
        rand_window(lo, hi);
        write_reg(CFG_ONE_MIN, lo);
        write_reg(CFG_ONE_MAX, hi);
    endtask

    task automatic send_frame();
        int nbits;
        logic [7:0] d;
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(3, 1))
                send_dur(pick_out(cur_cfg.leader_min, cur_cfg.leader_max));
        send_dur(pick_in(cur_cfg.leader_min, cur_cfg.leader_max));
        nbits = ($urandom_range(14) == 0) ? int'($urandom_range(31, 1)) : FRAME_BITS;
        for (int k = 0; k < nbits; k++) begin
            case ($urandom_range(11))
                0: d = pick_in(cur_cfg.leader_min, cur_cfg.leader_max);
                1: d = 8'($urandom_range(255));
                2, 3, 4, 5, 6: d = pick_in(cur_cfg.one_min, cur_cfg.one_max);
                default: d = pick_out(cur_cfg.one_min, cur_cfg.one_max);
            endcase
            send_dur(d);
        end
    endtask

    initial begin
        code_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            code_if.ready <= no_gaps || ($urandom_range(99) >= 34);
        end
    end

    always @(posedge i_clk) begin : code_check
        logic [31:0] want;
        if (i_rst_n && code_if.valid && code_if.ready) begin
            if (pending_codes.size() == 0) begin
                $display("%0t: unexpected code: expected none, got %h", $realtime, code_if.code);
                errors++;
            end else begin
                want = pending_codes.pop_front();
                if (code_if.code !== want) begin
                    $display("%0t: code mismatch: expected %h, got %h",
                             $realtime, want, code_if.code);
                    errors++;
                end
            end
        end
    end

    initial begin : stimulus
        t_row row;
        logic prev_reg;
        cycle = 0;
        errors = 0;
        busy_beats = 0;
        typed_on = 1'b0;
        typed_code = '0;
        cur_cfg = '{LEADER_MIN_RST, LEADER_MAX_RST, ONE_MIN_RST, ONE_MAX_RST};
        collecting = 1'b0;
        bit_cnt = '0;
        code_acc = '0;
        prev_reg = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_LEADER_MIN;
        i_cfg_data = '0;
        dur_if.valid = 1'b0;
        dur_if.duration = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < NROWS; r++) begin
            row = DIRECTED[r];
            if (row.kind == ROW_REG) begin
                if (!prev_reg)
                    drain();
                write_reg(row.idx, row.lead);
                prev_reg = 1'b1;
            end else begin
                typed_on = row.chk;
                typed_code = row.code;
                send_dur(row.lead);
                for (int k = 0; k < FRAME_BITS; k++)
                    send_dur(row.bits[k] ? row.one_d : row.zero_d);
                typed_on = 1'b0;
                prev_reg = 1'b0;
            end
        end

        busy_beats = 0;
        while (busy_beats < RAND_BEATS) begin
            configure_random();
            if (cur_cfg.leader_min > cur_cfg.leader_max) begin
                repeat (20) send_dur(8'($urandom_range(255)));
            end else begin
                repeat ($urandom_range(8, 3)) begin
                    send_frame();
                    if ($urandom_range(5) == 0)
                        drain();
                end
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (errors == 0 && pending_codes.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
